// ===== rtl/ous_pkg.sv =====
package ous_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned SetDepth = 16;
  localparam int unsigned CountW   = $clog2(SetDepth + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [ValueW-1:0]  element_value;
  } in_t;

  typedef struct packed {
    logic              was_present;
    logic [CountW-1:0] element_count;
    logic              full_reject;
  } out_t;

  typedef struct packed {
    logic [ValueW-1:0] key;
    logic              ins;
    logic              rem;
  } cell_ctrl_t;

endpackage

// ===== rtl/ous_cell.sv =====
module ous_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                         clk,
  input  ous_pkg::cell_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]             count,
  input  logic [ous_pkg::ValueW-1:0]   right_val,
  input  logic                         seen_in,
  output logic                         seen_out,
  output logic                         hit,
  output logic [ous_pkg::ValueW-1:0]   val
);

  logic [ous_pkg::ValueW-1:0] val_r;
  logic [ous_pkg::ValueW-1:0] val_nxt;
  logic                       occupied;

  assign occupied = CNT_W'(IDX) < count;
  assign hit      = occupied && (val_r == ctrl.key);
  assign seen_out = seen_in | hit;
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins && (count == CNT_W'(IDX))) begin
      val_nxt = ctrl.key;
    end else if (ctrl.rem && seen_out) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/ordered_unique_set_store.sv =====
// Ordered set of up to SET_DEPTH distinct signed 32-bit values, kept in
// insertion order in a row of cells. Each transaction on the input carries a
// mode (insert, remove, query, clear) and a value, and yields exactly one
// result transaction with the membership before the operation, the count
// after it and a flag for an insert refused because the set is full. All
// cells compare the value at once and a remove shifts every later cell down
// by one in the same cycle, so a transaction is taken every clock cycle; the
// result sits in a single output register and the input stalls only while
// that register holds a result that the output side stalls. Each result
// shows in the cycle after its input is taken. The count port is 5 bits wide.
module ordered_unique_set_store (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ous_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ous_pkg::out_t  out_data
);

  localparam int unsigned SET_DEPTH = ous_pkg::SetDepth;
  localparam int unsigned CNT_W     = ous_pkg::CountW;

  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  ous_pkg::out_t               out_data_r;
  ous_pkg::out_t               out_data_nxt;
  logic                        accept;
  logic                        present;
  logic                        full;
  logic                        reject;
  ous_pkg::cell_ctrl_t         ctrl;
  logic [SET_DEPTH:0]          seen;
  logic [SET_DEPTH-1:0]        hit_vec;
  logic [ous_pkg::ValueW-1:0]  cell_val [SET_DEPTH];

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign seen[0] = 1'b0;
  assign present = seen[SET_DEPTH];
  assign full    = count_r == CNT_W'(SET_DEPTH);
  assign reject  = (in_data.mode == ous_pkg::MODE_INSERT) && !present && full;

  always_comb begin
    ctrl.key = in_data.element_value;
    ctrl.ins = accept && (in_data.mode == ous_pkg::MODE_INSERT) && !present && !full;
    ctrl.rem = accept && (in_data.mode == ous_pkg::MODE_REMOVE) && present;
  end

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    logic [ous_pkg::ValueW-1:0] right_val;
    if (i == SET_DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end
    ous_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .right_val (right_val),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .hit       (hit_vec[i]),
      .val       (cell_val[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      case (in_data.mode)
        ous_pkg::MODE_INSERT: begin
          if (ctrl.ins) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ous_pkg::MODE_REMOVE: begin
          if (ctrl.rem) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        ous_pkg::MODE_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.was_present   = present;
      out_data_nxt.element_count = ous_pkg::CountW'(count_nxt);
      out_data_nxt.full_reject   = reject;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SET_DEPTH))
    else $error("held count beyond depth");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("value held in more than one cell");

  a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.full_reject |-> !out_data_r.was_present)
    else $error("refused insert of a value already held");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.mode == ous_pkg::MODE_CLEAR) |=> count_r == '0)
    else $error("clear left entries behind");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not drop the count");

endmodule

// ===== tb/tb_ordered_unique_set_store.sv =====
`timescale 1ns / 100ps

module tb_ordered_unique_set_store;

  localparam int unsigned SetDepth = ous_pkg::SetDepth;
  localparam int unsigned PoolN    = 24;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  ous_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  ous_pkg::out_t out_data;

  ordered_unique_set_store u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  logic [ous_pkg::ValueW-1:0] held_vals [SetDepth];
  int                         held_n;
  ous_pkg::out_t              status_q [$];
  logic [ous_pkg::ValueW-1:0] value_pool [PoolN];

  int unsigned in_acc_cnt;
  int unsigned res_cnt;
  int unsigned mismatches;
  int unsigned mode_cnt [4];
  int unsigned refused_cnt;
  int unsigned in_stall_cycles;
  int unsigned tx_gap;
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned rx_hold_len;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic ous_pkg::out_t apply_set_op(ous_pkg::in_t item);
    ous_pkg::out_t              r;
    int                         hit;
    int                         i;
    logic [ous_pkg::ValueW-1:0] v;
    v   = item.element_value;
    hit = -1;
    r   = '0;
    for (i = 0; i < held_n; i++) begin
      if (hit < 0 && held_vals[i] == v) hit = i;
    end
    case (item.mode)
      ous_pkg::MODE_INSERT: begin
        if (hit < 0) begin
          if (held_n < SetDepth) begin
            held_vals[held_n] = v;
            held_n++;
          end else begin
            r.full_reject = 1'b1;
          end
        end
      end
      ous_pkg::MODE_REMOVE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < held_n; i++) held_vals[i] = held_vals[i+1];
          held_n--;
        end
      end
      ous_pkg::MODE_QUERY: begin
      end
      default: begin
        held_n = 0;
      end
    endcase
    r.was_present   = (hit >= 0);
    r.element_count = ous_pkg::CountW'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin
    ous_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        res_cnt <= res_cnt + 1;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: present=%0b count=%0d reject=%0b",
                     $time, out_data.was_present, out_data.element_count,
                     out_data.full_reject);
        end else begin
          want = status_q.pop_front();
          if (out_data.was_present !== want.was_present ||
              out_data.element_count !== want.element_count ||
              out_data.full_reject !== want.full_reject) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp present=%0b count=%0d reject=%0b, got %0b/%0d/%0b",
                       $time, want.was_present, want.element_count, want.full_reject,
                       out_data.was_present, out_data.element_count,
                       out_data.full_reject);
          end
        end
      end
      if (in_valid && in_stall) in_stall_cycles++;
      if (in_valid && !in_stall) begin
        in_acc_cnt <= in_acc_cnt + 1;
        mode_cnt[in_data.mode]++;
        want = apply_set_op(in_data);
        if (want.full_reject) refused_cnt++;
        status_q.push_back(want);
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_n;
    int unsigned seen;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_len != 0) begin
        stall_n     = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall_n = rx_quiet ? 0 : $urandom_range(0, 9);
      end
      if (stall_n != 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      seen = res_cnt;
      do @(negedge clk); while (res_cnt == seen);
    end
  end

  task automatic send_item(input ous_pkg::mode_t m, input logic [ous_pkg::ValueW-1:0] v);
    int unsigned seen;
    if (tx_gap != 0) repeat (tx_gap) @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{mode: m, element_value: v};
    seen = in_acc_cnt;
    do @(negedge clk); while (in_acc_cnt == seen);
    tx_gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (tx_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic idle_input();
    if (tx_gap == 0) begin
      in_valid <= 1'b0;
      tx_gap = 1;
    end
  endtask

  task automatic wait_drained();
    idle_input();
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic ous_pkg::mode_t pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ous_pkg::MODE_INSERT;
    if (r < 70) return ous_pkg::MODE_REMOVE;
    if (r < 97) return ous_pkg::MODE_QUERY;
    return ous_pkg::MODE_CLEAR;
  endfunction

  function automatic logic [ous_pkg::ValueW-1:0] pick_value();
    if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, PoolN - 1)];
    return $urandom();
  endfunction

  task automatic test_extremes_and_ops();
    send_item(ous_pkg::MODE_INSERT, 32'h8000_0000);
    send_item(ous_pkg::MODE_INSERT, 32'h7FFF_FFFF);
    send_item(ous_pkg::MODE_INSERT, 32'h0000_0000);
    send_item(ous_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_item(ous_pkg::MODE_INSERT, 32'h0000_0000);
    send_item(ous_pkg::MODE_QUERY,  32'h7FFF_FFFF);
    send_item(ous_pkg::MODE_REMOVE, 32'h7FFF_FFFF);
    send_item(ous_pkg::MODE_REMOVE, 32'd12345);
  endtask

  task automatic test_full_store();
    int i;
    for (i = 0; i < 13; i++) send_item(ous_pkg::MODE_INSERT, 32'h0100_0000 + i);
    send_item(ous_pkg::MODE_INSERT, 32'hDEAD_BEEF);
    send_item(ous_pkg::MODE_INSERT, 32'h8000_0000);
    send_item(ous_pkg::MODE_CLEAR,  32'h0000_0000);
  endtask

  task automatic test_random_mix(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      send_item(pick_mode(), pick_value());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_output_hold();
    int unsigned k;
    tx_quiet    = 1'b1;
    rx_hold_len = 48;
    for (k = 0; k < 40; k++) send_item(pick_mode(), pick_value());
    tx_quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    int unsigned k;
    for (k = 0; k < 40; k++) send_item(pick_mode(), pick_value());
    wait_drained();
    for (k = 0; k < 40; k++) send_item(pick_mode(), pick_value());
  endtask

  initial begin : run
    int i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    held_n      = 0;
    tx_gap      = 0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    rx_hold_len = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h8000_0001;
    for (i = 6; i < PoolN; i++) value_pool[i] = $urandom();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes_and_ops();
    test_full_store();
    test_random_mix(500);
    test_output_hold();
    test_drain_pause();
    test_random_mix(80);
    wait_drained();

    if (status_q.size() != 0) begin
      mismatches += status_q.size();
      $display("%0d results never arrived", status_q.size());
    end
    $display("Covered %0d transactions: %0d insert, %0d remove, %0d query, %0d clear",
             in_acc_cnt, mode_cnt[ous_pkg::MODE_INSERT], mode_cnt[ous_pkg::MODE_REMOVE],
             mode_cnt[ous_pkg::MODE_QUERY], mode_cnt[ous_pkg::MODE_CLEAR]);
    $display("Inserts refused on a full store: %0d, input stall cycles: %0d",
             refused_cnt, in_stall_cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
